// File: rtl/core/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
package lir_pkg;

   localparam int CHANNEL_SLOTS = 8;
   localparam int CHAN_W        = 3;
   localparam int CNT_W         = 4;
   localparam int SAMPLE_W      = 32;
   localparam int FRAC_BITS     = 32;
   localparam int STEP_W        = 40;
   localparam int ACC_W         = 41;
   localparam int DIFF_W        = SAMPLE_W + 1;
   localparam int PROD_W        = 2 * DIFF_W;
   localparam int RND_W         = PROD_W - FRAC_BITS;
   localparam int S24_W         = 24;

   localparam logic [ACC_W-1:0]  ONE_FIX  = ACC_W'(1) << FRAC_BITS;
   localparam logic [STEP_W-1:0] ONE_STEP = STEP_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0] HALF_FIX = PROD_W'(1) << (FRAC_BITS - 1);

   typedef enum logic [0:0] {
      CSR_CHANNEL_COUNT = 1'b0,
      CSR_STEP_FIXED    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] older;
      logic signed [DIFF_W-1:0]   diff;
      logic [FRAC_BITS-1:0]       frac;
      logic                       copy;
      logic [CHAN_W-1:0]          chan;
   } op_type;

   typedef struct packed {
      logic first_frame;
      logic acc_below_one;
   } status_type;

endpackage

// File: rtl/core/linear_interp_resampler_top.sv
// Top level of the linear interpolation resampler.
// Interleaved samples enter on the req_ stream, channel 0 first in each frame.
// Each frame closes the interval to the previous frame; when the output
// position lies in that interval, every sample of the frame produces one
// result on the rsp_ stream, with its channel index in rsp_tuser.
// The csr_ port sets the channel count and the Q8.32 step; write it only
// while no transaction is in flight.
// The operands of each result pass through the three register stages of the
// blend pipeline (operands, multiply, round and saturate) before the result
// appears. The block accepts one sample per cycle while req_tready is high.
// Reset sets one channel, a step of 1.0, clears the previous samples and the
// position, and makes the first frame only load the previous samples.
// When the receiver stalls, the three stages fill and req_tready then drops
// for samples that produce a result until rsp_tready returns; samples without
// a result are still accepted.
module linear_interp_resampler_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lir_pkg::SAMPLE_W-1:0]  req_tdata,   // [31:0] sample
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lir_pkg::SAMPLE_W-1:0]  rsp_tdata,   // [31:0] out_sample
   output logic [lir_pkg::CHAN_W-1:0]    rsp_tuser,   // [2:0] out_channel
   input  logic                          csr_we,
   input  lir_pkg::csr_index_type        csr_index,
   input  logic [lir_pkg::STEP_W-1:0]    csr_wdata
);
   import lir_pkg::*;

   logic       accept;
   op_type     frame_op;
   logic       op_emit;
   status_type frame_status;
   logic       blend_ready;

   assign req_tready = blend_ready || !op_emit;
   assign accept     = req_tvalid && req_tready;

   lir_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .sample    (req_tdata),
      .op        (frame_op),
      .op_emit   (op_emit),
      .status    (frame_status)
   );

   lir_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid && op_emit),
      .in_ready   (blend_ready),
      .in_op      (frame_op),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_sample (rsp_tdata),
      .out_chan   (rsp_tuser)
   );

   a_reset_clears_output: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_first_frame_silent: assert property (@(posedge clock) disable iff (reset)
      frame_status.first_frame |-> !op_emit)
      else $error("Result requested during the first frame.");

   a_emit_in_interval: assert property (@(posedge clock) disable iff (reset)
      op_emit |-> frame_status.acc_below_one)
      else $error("Result requested with the position outside the interval.");

endmodule

// File: rtl/core/lir_frame.sv
// Frame tracking: channel counter, position accumulator, previous samples and registers.
module lir_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  lir_pkg::csr_index_type        csr_index,
   input  logic [lir_pkg::STEP_W-1:0]    csr_wdata,
   input  logic                          accept,
   input  logic [lir_pkg::SAMPLE_W-1:0]  sample,
   output lir_pkg::op_type               op,
   output logic                          op_emit,
   output lir_pkg::status_type           status
);
   import lir_pkg::*;

   logic [CNT_W-1:0]    chan_count_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [SAMPLE_W-1:0] prev_ff [CHANNEL_SLOTS];
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CHAN_W-1:0]   cnt_ff, cnt_in;
   logic                first_ff, first_in;
   logic                emit_ff, emit_in;

   logic [CNT_W-1:0]    n_active;
   logic                last;
   logic                below_one;
   logic                emit_now;
   logic [SAMPLE_W-1:0] older;
   logic [ACC_W-1:0]    step_eff;

   always_comb begin
      if (chan_count_ff == '0) begin
         n_active = CNT_W'(1);
      end else if (chan_count_ff > CNT_W'(CHANNEL_SLOTS)) begin
         n_active = CNT_W'(CHANNEL_SLOTS);
      end else begin
         n_active = chan_count_ff;
      end
      last      = (CNT_W'(cnt_ff) + CNT_W'(1)) >= n_active;
      below_one = (acc_ff[ACC_W-1:FRAC_BITS] == '0);
      emit_now  = (cnt_ff == '0) ? below_one : emit_ff;
      older     = prev_ff[cnt_ff];
      step_eff  = (step_ff[STEP_W-1:FRAC_BITS] == '0) ? ONE_FIX : ACC_W'(step_ff);

      op.older = older;
      op.diff  = $signed({sample[SAMPLE_W-1], sample}) - $signed({older[SAMPLE_W-1], older});
      op.frac  = acc_ff[FRAC_BITS-1:0];
      op.copy  = (acc_ff[FRAC_BITS-1:0] == '0);
      op.chan  = cnt_ff;
      op_emit  = !first_ff && emit_now;

      status.first_frame   = first_ff;
      status.acc_below_one = below_one;

      cnt_in   = cnt_ff;
      first_in = first_ff;
      emit_in  = emit_ff;
      acc_in   = acc_ff;
      if (accept) begin
         cnt_in = last ? '0 : cnt_ff + CHAN_W'(1);
         if (first_ff) begin
            first_in = !last;
         end else begin
            emit_in = emit_now;
            if (last) begin
               acc_in = acc_ff + (emit_now ? step_eff : '0) - ONE_FIX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_count_ff <= CNT_W'(1);
         step_ff       <= ONE_STEP;
         acc_ff        <= '0;
         cnt_ff        <= '0;
         first_ff      <= 1'b1;
         emit_ff       <= 1'b0;
         for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: chan_count_ff <= csr_wdata[CNT_W-1:0];
               CSR_STEP_FIXED:    step_ff       <= csr_wdata[STEP_W-1:0];
               default:           ;
            endcase
         end
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         first_ff <= first_in;
         emit_ff  <= emit_in;
         if (accept) begin
            prev_ff[cnt_ff] <= sample;
         end
      end
   end

endmodule

// File: rtl/core/lir_blend.sv
// Three-stage blend pipeline: operand register, multiply, round and saturate.
module lir_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  lir_pkg::op_type               in_op,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [lir_pkg::SAMPLE_W-1:0]  out_sample,
   output logic [lir_pkg::CHAN_W-1:0]    out_chan
);
   import lir_pkg::*;

   logic                       v1_ff, v2_ff, v3_ff;
   logic                       adv1, adv2, adv3;
   op_type                     op1_ff;
   logic signed [PROD_W-1:0]   prod_in, prod2_ff;
   logic [SAMPLE_W-1:0]        older2_ff;
   logic                       copy2_ff;
   logic [CHAN_W-1:0]          chan2_ff, chan3_ff;
   logic [SAMPLE_W-1:0]        sample_in, sample3_ff;
   logic [PROD_W-1:0]          sum;
   logic [RND_W-1:0]           rounded;
   logic [SAMPLE_W-1:0]        sat;

   assign adv3     = !v3_ff || out_ready;
   assign adv2     = !v2_ff || adv3;
   assign adv1     = !v1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      prod_in = $signed(op1_ff.diff) * $signed({1'b0, op1_ff.frac});
      sum     = {{(PROD_W-SAMPLE_W-FRAC_BITS){older2_ff[SAMPLE_W-1]}}, older2_ff,
                 {FRAC_BITS{1'b0}}} + prod2_ff + HALF_FIX;
      rounded = sum[PROD_W-1:FRAC_BITS];
      if (!rounded[RND_W-1] && (rounded[RND_W-2:S24_W-1] != '0)) begin
         sat = SAMPLE_W'(24'h7FFFFF);
      end else if (rounded[RND_W-1] && (rounded[RND_W-2:S24_W-1] != '1)) begin
         sat = {{(SAMPLE_W-S24_W){1'b1}}, 24'h800000};
      end else begin
         sat = {{(SAMPLE_W-S24_W){rounded[S24_W-1]}}, rounded[S24_W-1:0]};
      end
      sample_in = copy2_ff ? older2_ff : sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         op1_ff <= in_op;
      end
      if (adv2) begin
         prod2_ff  <= prod_in;
         older2_ff <= op1_ff.older;
         copy2_ff  <= op1_ff.copy;
         chan2_ff  <= op1_ff.chan;
      end
      if (adv3) begin
         sample3_ff <= sample_in;
         chan3_ff   <= chan2_ff;
      end
   end

   assign out_valid  = v3_ff;
   assign out_sample = sample3_ff;
   assign out_chan   = chan3_ff;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the linear interpolation resampler stream block.
`timescale 1ns / 100ps

module testbench;
   import lir_pkg::*;

   localparam int RANDOM_ITEMS   = 1150;
   localparam int QUIET_TAIL     = 150;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PLAN_ROWS      = 32;

   typedef enum logic [2:0] {
      ROW_OPEN,
      ROW_SILENT,
      ROW_RESULT,
      ROW_CC,
      ROW_STEP
   } plan_kind_type;

   typedef struct packed {
      plan_kind_type kind;
      logic [39:0]   value;
      logic [31:0]   want;
      logic [2:0]    want_ch;
   } plan_row_type;

   typedef struct packed {
      logic [31:0] smp;
      logic [2:0]  ch;
   } resampled_item_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_tvalid  = 1'b0;
   logic          req_tready;
   logic [31:0]   req_tdata   = '0;
   logic          rsp_tvalid;
   logic          rsp_tready  = 1'b0;
   logic [31:0]   rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          csr_we      = 1'b0;
   csr_index_type csr_index   = CSR_CHANNEL_COUNT;
   logic [39:0]   csr_wdata   = '0;

   plan_kind_type req_kind    = ROW_OPEN;
   logic [31:0]   req_want    = '0;
   logic [2:0]    req_want_ch = '0;

   logic [3:0]    cc_model;
   logic [39:0]   step_model;
   logic [31:0]   older_model [CHANNEL_SLOTS];
   logic [40:0]   position_model;
   logic [2:0]    chan_model;
   bit            first_model;
   bit            emit_model;

   resampled_item_type due_results [$];
   plan_row_type       plan [PLAN_ROWS];

   int            gap_pct     = 0;
   int            stall_pct   = 0;
   int            stall_left  = 0;
   int            idle_cycles = 0;
   int            mismatches  = 0;
   int            samples_in  = 0;
   int            results_out = 0;
   int            phase_count = 0;

   linear_interp_resampler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] blend_samples(input logic [31:0] older,
                                                 input logic [31:0] newer,
                                                 input logic [31:0] frac);
      logic signed [79:0] a;
      logic signed [79:0] b;
      logic signed [79:0] f;
      logic signed [79:0] sum;
      logic signed [79:0] shifted;
      a = 80'(signed'(older));
      b = 80'(signed'(newer));
      f = 80'(frac);
      sum = a * (80'sh1_0000_0000 - f) + b * f + 80'sh8000_0000;
      shifted = sum >>> 32;
      if (shifted > 80'sd8388607) begin
         shifted = 80'sd8388607;
      end else if (shifted < -80'sd8388608) begin
         shifted = -80'sd8388608;
      end
      return shifted[31:0];
   endfunction

   function automatic void resample_sample(input logic [31:0] s, output bit hit,
                                           output logic [31:0] v, output logic [2:0] ch);
      int          n;
      bit          last;
      logic [31:0] frac;
      logic [40:0] st;
      n = (cc_model == 4'd0) ? 1 : (cc_model > CHANNEL_SLOTS) ? CHANNEL_SLOTS : int'(cc_model);
      last = (int'(chan_model) + 1 >= n);
      hit = 1'b0;
      v = '0;
      ch = chan_model;
      if (first_model) begin
         older_model[chan_model] = s;
         if (last) begin
            first_model = 1'b0;
         end
      end else begin
         if (chan_model == 3'd0) begin
            emit_model = (position_model < ONE_FIX);
         end
         if (emit_model) begin
            frac = position_model[31:0];
            hit = 1'b1;
            v = (frac == 32'd0) ? older_model[chan_model]
                                : blend_samples(older_model[chan_model], s, frac);
         end
         older_model[chan_model] = s;
         if (last) begin
            st = (step_model < ONE_STEP) ? 41'(ONE_STEP) : 41'(step_model);
            if (emit_model) begin
               position_model = position_model + st;
            end
            position_model = position_model - ONE_FIX;
         end
      end
      chan_model = last ? 3'd0 : chan_model + 3'd1;
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s", msg);
      end
   endtask

   always @(posedge clock) begin
      resampled_item_type got;
      bit                 hit;
      logic [31:0]        v;
      logic [2:0]         ch;
      if (reset) begin
         cc_model = 4'd1;
         step_model = ONE_STEP;
         for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            older_model[i] = '0;
         end
         position_model = '0;
         chan_model = '0;
         first_model = 1'b1;
         emit_model = 1'b0;
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHANNEL_COUNT: cc_model = csr_wdata[3:0];
               CSR_STEP_FIXED:    step_model = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            results_out++;
            if (due_results.size() == 0) begin
               report($sformatf("result %h channel %0d with none expected",
                                rsp_tdata, rsp_tuser));
            end else begin
               got = due_results.pop_front();
               if (got.smp !== rsp_tdata || got.ch !== rsp_tuser) begin
                  report($sformatf("expected %h channel %0d, got %h channel %0d",
                                   got.smp, got.ch, rsp_tdata, rsp_tuser));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            samples_in++;
            resample_sample(req_tdata, hit, v, ch);
            case (req_kind)
               ROW_RESULT: due_results.push_back('{smp: req_want, ch: req_want_ch});
               ROW_SILENT: ;
               default: begin
                  if (hit) begin
                     due_results.push_back('{smp: v, ch: ch});
                  end
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic [31:0] s, input plan_kind_type kind,
                              input logic [31:0] want, input logic [2:0] want_ch);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= s;
      req_kind    <= kind;
      req_want    <= want;
      req_want_ch <= want_ch;
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [39:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [31:0] pick_sample();
      logic [31:0] extremes [6];
      extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                   32'hFFFF_FFFF, 32'h007F_FFFF, 32'hFF80_0000};
      case ($urandom_range(0, 9))
         0:       return extremes[$urandom_range(0, 5)];
         1, 2, 3: return $urandom;
         default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      endcase
   endfunction

   function automatic logic [39:0] pick_step();
      case ($urandom_range(0, 9))
         0:       return 40'($urandom);
         1:       return 40'($urandom_range(1, 4)) << 32;
         2:       return (40'($urandom_range(4, 15)) << 32) | 40'($urandom);
         default: return (40'($urandom_range(1, 2)) << 32) | 40'($urandom);
      endcase
   endfunction

   function automatic logic [39:0] pick_channels();
      logic [3:0] cc;
      cc = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(1, CHANNEL_SLOTS));
      return {36'($urandom) & {36{$urandom_range(0, 1) == 1}}, cc};
   endfunction

   initial begin
      int random_items;
      int span;
      int pcts [3];
      pcts = '{0, 10, 35};
      plan = '{
         '{ROW_SILENT, 40'd100,           32'd0,           3'd0},
         '{ROW_RESULT, 40'd200,           32'd100,         3'd0},
         '{ROW_RESULT, 40'h00_7FFF_FFFF,  32'd200,         3'd0},
         '{ROW_RESULT, 40'h00_8000_0000,  32'h7FFF_FFFF,   3'd0},
         '{ROW_RESULT, 40'h00_0000_0000,  32'h8000_0000,   3'd0},
         '{ROW_STEP,   40'h01_8000_0000,  32'd0,           3'd0},
         '{ROW_RESULT, 40'h00_7FFF_FFFF,  32'd0,           3'd0},
         '{ROW_RESULT, 40'h00_7FFF_FFFF,  32'h007F_FFFF,   3'd0},
         '{ROW_SILENT, 40'h00_8000_0000,  32'd0,           3'd0},
         '{ROW_RESULT, 40'h00_8000_0000,  32'h8000_0000,   3'd0},
         '{ROW_RESULT, 40'h00_8000_0000,  32'hFF80_0000,   3'd0},
         '{ROW_SILENT, 40'd1000,          32'd0,           3'd0},
         '{ROW_STEP,   40'h00_0000_0000,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_FFFF_FFFB,  32'd0,           3'd0},
         '{ROW_CC,     40'd15,            32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_0000_0001,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_FFFF_FFFF,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_0080_0000,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_FF7F_FFFF,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_5555_5555,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_AAAA_AAAA,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_1234_5678,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_EDCB_A987,  32'd0,           3'd0},
         '{ROW_CC,     40'd3,             32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_007F_FFFF,  32'd0,           3'd0},
         '{ROW_CC,     40'd1,             32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_FF80_0000,  32'd0,           3'd0},
         '{ROW_CC,     40'd0,             32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_0000_0002,  32'd0,           3'd0},
         '{ROW_STEP,   40'hFF_FFFF_FFFF,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_0000_0003,  32'd0,           3'd0},
         '{ROW_OPEN,   40'h00_0000_0004,  32'd0,           3'd0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_CC:   write_csr(CSR_CHANNEL_COUNT, plan[i].value);
            ROW_STEP: write_csr(CSR_STEP_FIXED, plan[i].value);
            default:  send_sample(plan[i].value[31:0], plan[i].kind,
                                  plan[i].want, plan[i].want_ch);
         endcase
      end

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase_count++;
         if (random_items >= RANDOM_ITEMS - QUIET_TAIL) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = pcts[$urandom_range(0, 2)];
            stall_pct = pcts[$urandom_range(0, 2)];
         end
         case ($urandom_range(0, 3))
            0:       write_csr(CSR_CHANNEL_COUNT, pick_channels());
            1:       write_csr(CSR_STEP_FIXED, pick_step());
            default: begin
               write_csr(CSR_CHANNEL_COUNT, pick_channels());
               write_csr(CSR_STEP_FIXED, pick_step());
            end
         endcase
         span = $urandom_range(8, 80);
         repeat (span) begin
            send_sample(pick_sample(), ROW_OPEN, '0, '0);
            random_items++;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_results.size() != 0) begin
         mismatches++;
      end

      $display("Sent %0d samples over %0d configuration phases; %0d results checked.",
               samples_in, phase_count, results_out);
      $display("Mismatches counted: %0d.", mismatches);
      if (mismatches == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
